>>> src/kts_pkg.sv
`timescale 1ns / 1ps
// Package for the knapsack tabu search core: sequencer states, register
// indexes and fixed result field widths. No dependencies.
package kts_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_G_CHK,
    ST_G_RD,
    ST_G_MUL,
    ST_G_CMP,
    ST_G_END,
    ST_T_INIT,
    ST_T_IMUL,
    ST_T_ISUB,
    ST_T_CHK,
    ST_T_RD,
    ST_T_S1,
    ST_T_S2,
    ST_T_S3,
    ST_T_END,
    ST_DONE
  } kts_state_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TENURE    = 2'd2;

  localparam int unsigned CAP_W    = 22;
  localparam int unsigned ITER_W   = 16;
  localparam int unsigned TEN_W    = 6;
  localparam int unsigned EXP_W    = ITER_W + 1;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned OMASK_W  = 64;
  localparam int unsigned OOBJ_W   = 45;
  localparam int unsigned OSUM_W   = 22;
  localparam int unsigned OCNT_W   = 7;
  localparam int unsigned IN_DATA_W  = 2 * FIELD_W;
  localparam int unsigned OUT_DATA_W = OMASK_W + OOBJ_W + 2 * OSUM_W + OCNT_W;

  localparam logic [ITER_W-1:0] ITER_LIM_RST = 16'd100;
  localparam logic [TEN_W-1:0]  TENURE_RST   = 6'd2;

endpackage

>>> src/kts_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/knapsack_tabu_search_core.sv
`timescale 1ns / 1ps
// Knapsack tabu search core. Loads one item per cycle while in its load
// state; the last item starts a greedy start (read, multiply and compare
// states per unmasked item per round) and a tabu search over items in RAM.
// Result latency is set by these scans; items of the next problem load
// while a result waits. Reset clears counters, sums and tabu valid bits;
// item and tabu RAMs hold no reset value. Depends on kts_pkg and kts_ram.
module knapsack_tabu_search_core
  import kts_pkg::*;
#(
  parameter int unsigned MAX_ITEMS   = 64,
  parameter int unsigned VALUE_BITS  = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // item_value, item_weight
  input  logic                  s_axis_tlast,  // last_item
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // best_mask, best_objective, best_weight, best_profit, item_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IDX_W  = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned MAXVW  = (VALUE_BITS > WEIGHT_BITS) ? VALUE_BITS : WEIGHT_BITS;
  localparam int unsigned SUM_W  = MAXVW + IDX_W + 1;
  localparam int unsigned CW     = (SUM_W > CAP_W) ? SUM_W : CAP_W;
  localparam int unsigned PROD_W = 2 * SUM_W;
  localparam int unsigned OBJ_W  = PROD_W + 1;
  localparam int unsigned GP_W   = VALUE_BITS + WEIGHT_BITS;
  localparam int unsigned ITEM_W = VALUE_BITS + WEIGHT_BITS;

  kts_state_e state_q, state_d;

  logic [CAP_W-1:0]  cap_q;
  logic [ITER_W-1:0] iter_lim_q;
  logic [TEN_W-1:0]  tenure_q;

  logic [CNT_W-1:0]     cnt_q, cnt_d, idx_q, idx_d;
  logic [IDX_W-1:0]     b_q, b_d;
  logic                 found_q, found_d;
  logic [MAX_ITEMS-1:0] mask_q, mask_d, best_mask_q, best_mask_d;
  logic [MAX_ITEMS-1:0] tvld_q, tvld_d;
  logic [SUM_W-1:0]     cw_q, cw_d, cp_q, cp_d, all_q, all_d;
  logic [SUM_W-1:0]     bsw_q, bsw_d, bsp_q, bsp_d;
  logic signed [OBJ_W-1:0] best_obj_q, best_obj_d, beste_q, beste_d, eval_c;
  logic [ITER_W-1:0]    iter_q, iter_d;
  logic [VALUE_BITS-1:0]  bv_q, bv_d, cv_q, cv_d;
  logic [WEIGHT_BITS-1:0] bwt_q, bwt_d, cwt_q, cwt_d;
  logic [GP_W-1:0]      pa_q, pa_d, pb_q, pb_d;
  logic [SUM_W-1:0]     p_q, p_d, ex_q, ex_d, w_c;
  logic [PROD_W-1:0]    prod_q, prod_d;

  logic                 out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_q, out_d;

  logic                   item_we;
  logic [IDX_W-1:0]       item_waddr;
  logic [ITEM_W-1:0]      item_wdata, item_rdata;
  logic                   tabu_we;
  logic [EXP_W-1:0]       tabu_wdata, tabu_rdata;
  logic [VALUE_BITS-1:0]  rd_v;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic                   in_beat, full, is_tabu;

  kts_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (item_we),
    .waddr_i (item_waddr),
    .wdata_i (item_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (item_rdata)
  );

  kts_ram #(.WIDTH(EXP_W), .DEPTH(MAX_ITEMS)) u_tabu_ram (
    .clk_i   (clk_i),
    .we_i    (tabu_we),
    .waddr_i (b_q),
    .wdata_i (tabu_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (tabu_rdata)
  );

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign full       = (cnt_q == CNT_W'(MAX_ITEMS));
  assign item_we    = in_beat && !full;
  assign item_waddr = cnt_q[IDX_W-1:0];
  assign item_wdata = {WEIGHT_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]),
                       VALUE_BITS'(s_axis_tdata[FIELD_W-1:0])};
  assign rd_v       = item_rdata[VALUE_BITS-1:0];
  assign rd_w       = item_rdata[ITEM_W-1:VALUE_BITS];
  assign tabu_we    = (state_q == ST_T_END) && found_q;
  assign tabu_wdata = EXP_W'(iter_q) + EXP_W'(tenure_q);
  assign is_tabu    = tvld_q[idx_q[IDX_W-1:0]] && ({1'b0, iter_q} <= tabu_rdata);
  assign eval_c     = $signed(OBJ_W'(p_q)) - $signed(OBJ_W'(prod_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:   if (in_beat && s_axis_tlast) state_d = ST_G_CHK;
      ST_G_CHK:  state_d = (CW'(cw_q) < CW'(cap_q)) ? ST_G_RD : ST_T_INIT;
      ST_G_RD: begin
        if (idx_q == cnt_q) begin
          state_d = ST_G_END;
        end else if (!mask_q[idx_q[IDX_W-1:0]]) begin
          state_d = ST_G_MUL;
        end
      end
      ST_G_MUL:  state_d = ST_G_CMP;
      ST_G_CMP:  state_d = ST_G_RD;
      ST_G_END: begin
        if (!found_q || (CW'(cw_q) + CW'(bwt_q)) > CW'(cap_q)) begin
          state_d = ST_T_INIT;
        end else begin
          state_d = ST_G_CHK;
        end
      end
      ST_T_INIT: state_d = ST_T_IMUL;
      ST_T_IMUL: state_d = ST_T_ISUB;
      ST_T_ISUB: state_d = ST_T_CHK;
      ST_T_CHK:  state_d = (iter_q < iter_lim_q) ? ST_T_RD : ST_DONE;
      ST_T_RD:   state_d = (idx_q == cnt_q) ? ST_T_END : ST_T_S1;
      ST_T_S1:   state_d = is_tabu ? ST_T_RD : ST_T_S2;
      ST_T_S2:   state_d = ST_T_S3;
      ST_T_S3:   state_d = ST_T_RD;
      ST_T_END:  state_d = ST_T_CHK;
      ST_DONE:   if (!out_vld_q) state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; b_d = b_q; found_d = found_q;
    mask_d = mask_q; best_mask_d = best_mask_q; tvld_d = tvld_q;
    cw_d = cw_q; cp_d = cp_q; all_d = all_q; bsw_d = bsw_q; bsp_d = bsp_q;
    best_obj_d = best_obj_q; beste_d = beste_q; iter_d = iter_q;
    bv_d = bv_q; bwt_d = bwt_q; cv_d = cv_q; cwt_d = cwt_q;
    pa_d = pa_q; pb_d = pb_q; p_d = p_q; ex_d = ex_q; prod_d = prod_q;
    out_vld_d = out_vld_q; out_d = out_q;
    w_c = '0;
    if (out_vld_q && m_axis_tready) out_vld_d = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (item_we) begin
          cnt_d = cnt_q + 1'b1;
          all_d = all_q + SUM_W'(item_wdata[VALUE_BITS-1:0]);
        end
        if (in_beat && s_axis_tlast) begin
          mask_d = '0; cw_d = '0; cp_d = '0;
        end
      end
      ST_G_CHK: begin
        idx_d = '0; found_d = 1'b0;
      end
      ST_G_RD: begin
        if (idx_q != cnt_q && mask_q[idx_q[IDX_W-1:0]]) idx_d = idx_q + 1'b1;
      end
      ST_G_MUL: begin
        cv_d = rd_v; cwt_d = rd_w;
        pa_d = GP_W'(rd_v) * GP_W'(bwt_q);
        pb_d = GP_W'(bv_q) * GP_W'(rd_w);
      end
      ST_G_CMP: begin
        if ((!found_q && cv_q != '0) || (found_q && pa_q > pb_q)) begin
          found_d = 1'b1; b_d = idx_q[IDX_W-1:0]; bv_d = cv_q; bwt_d = cwt_q;
        end
        idx_d = idx_q + 1'b1;
      end
      ST_G_END: begin
        if (found_q && (CW'(cw_q) + CW'(bwt_q)) <= CW'(cap_q)) begin
          cw_d = cw_q + SUM_W'(bwt_q);
          cp_d = cp_q + SUM_W'(bv_q);
          mask_d[b_q] = 1'b1;
        end
      end
      ST_T_INIT: begin
        tvld_d = '0; best_mask_d = mask_q; bsw_d = cw_q; bsp_d = cp_q;
        iter_d = '0; p_d = cp_q;
        ex_d = (CW'(cw_q) > CW'(cap_q)) ? SUM_W'(CW'(cw_q) - CW'(cap_q)) : '0;
      end
      ST_T_IMUL: prod_d = PROD_W'(all_q) * PROD_W'(ex_q);
      ST_T_ISUB: best_obj_d = eval_c;
      ST_T_CHK: begin
        idx_d = '0; found_d = 1'b0;
      end
      ST_T_RD: ;
      ST_T_S1: begin
        if (is_tabu) begin
          idx_d = idx_q + 1'b1;
        end else begin
          cv_d = rd_v; cwt_d = rd_w;
          if (mask_q[idx_q[IDX_W-1:0]]) begin
            p_d = cp_q - SUM_W'(rd_v);
            w_c = cw_q - SUM_W'(rd_w);
          end else begin
            p_d = cp_q + SUM_W'(rd_v);
            w_c = cw_q + SUM_W'(rd_w);
          end
          ex_d = (CW'(w_c) > CW'(cap_q)) ? SUM_W'(CW'(w_c) - CW'(cap_q)) : '0;
        end
      end
      ST_T_S2: prod_d = PROD_W'(all_q) * PROD_W'(ex_q);
      ST_T_S3: begin
        if (!found_q || eval_c > beste_q) begin
          found_d = 1'b1; b_d = idx_q[IDX_W-1:0]; beste_d = eval_c;
          bv_d = cv_q; bwt_d = cwt_q;
        end
        idx_d = idx_q + 1'b1;
      end
      ST_T_END: begin
        if (found_q) begin
          tvld_d[b_q] = 1'b1;
          if (mask_q[b_q]) begin
            cp_d = cp_q - SUM_W'(bv_q);
            cw_d = cw_q - SUM_W'(bwt_q);
          end else begin
            cp_d = cp_q + SUM_W'(bv_q);
            cw_d = cw_q + SUM_W'(bwt_q);
          end
          mask_d[b_q] = ~mask_q[b_q];
          if (beste_q > best_obj_q) begin
            best_obj_d = beste_q; best_mask_d = mask_d;
            bsw_d = cw_d; bsp_d = cp_d;
          end
        end
        iter_d = iter_q + 1'b1;
      end
      ST_DONE: begin
        if (!out_vld_q) begin
          out_vld_d = 1'b1;
          out_d = {OCNT_W'(cnt_q), OSUM_W'(bsp_q), OSUM_W'(bsw_q),
                   OOBJ_W'(best_obj_q), OMASK_W'(best_mask_q)};
          cnt_d = '0; all_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cap_q <= '0; iter_lim_q <= ITER_LIM_RST; tenure_q <= TENURE_RST;
      cnt_q <= '0; idx_q <= '0; found_q <= 1'b0; tvld_q <= '0;
      mask_q <= '0; best_mask_q <= '0; cw_q <= '0; cp_q <= '0; all_q <= '0;
      bsw_q <= '0; bsp_q <= '0; best_obj_q <= '0; iter_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CAPACITY: cap_q <= cfg_data_i;
          REG_ITER_LIM: iter_lim_q <= cfg_data_i[ITER_W-1:0];
          REG_TENURE:   tenure_q <= cfg_data_i[TEN_W-1:0];
          default: ;
        endcase
      end
      cnt_q <= cnt_d; idx_q <= idx_d; found_q <= found_d; tvld_q <= tvld_d;
      mask_q <= mask_d; best_mask_q <= best_mask_d;
      cw_q <= cw_d; cp_q <= cp_d; all_q <= all_d;
      bsw_q <= bsw_d; bsp_q <= bsp_d; best_obj_q <= best_obj_d; iter_q <= iter_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d; beste_q <= beste_d;
    bv_q <= bv_d; bwt_q <= bwt_d; cv_q <= cv_d; cwt_q <= cwt_d;
    pa_q <= pa_d; pb_q <= pb_d; p_q <= p_d; ex_q <= ex_d; prod_q <= prod_d;
    out_q <= out_d;
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ITEMS)) else $error("item count over store depth");

  a_greedy_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_T_INIT |-> CW'(cw_q) <= CW'(cap_q))
    else $error("greedy start over capacity");

  a_result_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_vld_q) |=> (out_vld_q && state_q == ST_LOAD))
    else $error("result not issued");

  a_tabu_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_T_END && found_q) |=> tvld_q[$past(b_q)])
    else $error("chosen flip not marked tabu");

endmodule
